// File: rtl/rvad_pkg.sv
// Package for the RMS voice activity detector: widths, constants, shared types.
`timescale 1ns / 1ps
package rvad_pkg;

    // Frame and sample geometry
    localparam int FRAME_MAX = 4096;
    localparam int SMP_W     = 16;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);
    localparam int SQ_W      = 2 * SMP_W - 1;              // |sample|^2 <= 2^30
    localparam int SUM_W     = SQ_W + CNT_W - 1;

    // Back end arithmetic
    localparam int Q_W        = SQ_W;                      // mean square fits a square
    localparam int REM_W      = CNT_W + 1;
    localparam int ROOT_STEPS = (SQ_W + 1) / 2;
    localparam int STEP_W     = $clog2(Q_W);
    localparam int E_W        = 16;
    localparam int SIL_W      = 25;

    // Configuration registers
    localparam int THR_W      = 16;
    localparam int HANG_W     = 24;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(655);
    localparam logic [HANG_W-1:0] HANG_RESET = HANG_W'(8000);
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_HANGOVER  = 1'b1;

    localparam logic [SQ_W-1:0] ENERGY_CLAMP = SQ_W'(32768);

    // Frame queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One closed frame on its way to the back end
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_frame;

    // Queue status seen by both sides
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_fifo_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } t_back_state;

endpackage

// File: rtl/rvad_fifo.sv
// Short frame queue between the accumulator and the RMS back end.
`timescale 1ns / 1ps
module rvad_fifo
    import rvad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame     i_frame,
    input  logic       i_pop,
    output t_frame     o_frame,
    output t_fifo_stat o_stat
);

    t_frame              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_frame;
    end

    assign o_frame      = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.empty = (r_cnt == '0);

endmodule

// File: rtl/rvad_front.sv
// Front end: takes sample beats, squares them and closes frames into the queue.
`timescale 1ns / 1ps
module rvad_front
    import rvad_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [SMP_W-1:0] i_sample,
    input  logic             i_frame_end,
    input  t_fifo_stat       i_stat,
    output logic             o_push,
    output t_frame           o_frame
);

    logic                r_a_valid;
    logic                r_a_close;
    logic [SQ_W-1:0]     r_a_sq;
    logic [CNT_W-1:0]    r_a_count;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;

    logic                accept;
    logic [SMP_W-1:0]    mag;
    logic [2*SMP_W-1:0]  prod;
    logic [CNT_W-1:0]    n_count;
    logic                close;
    logic [SUM_W-1:0]    n_sum;
    logic [QCNT_W:0]     credit;

    // Room check counts a closing beat still in the square stage
    assign credit  = (QCNT_W+1)'(i_stat.count) + (QCNT_W+1)'(r_a_valid && r_a_close);
    assign o_ready = (credit < (QCNT_W+1)'(QDEPTH));
    assign accept  = i_valid && o_ready;

    // Magnitude and square; -32768 maps to 32768
    assign mag     = i_sample[SMP_W-1] ? (~i_sample + SMP_W'(1)) : i_sample;
    assign prod    = mag * mag;
    assign n_count = r_count + CNT_W'(1);
    assign close   = i_frame_end || (n_count == CNT_W'(FRAME_MAX));

    // Square stage and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            r_a_valid <= accept;
            if (accept) r_count <= close ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_sq    <= prod[SQ_W-1:0];
            r_a_close <= close;
            r_a_count <= n_count;
        end
    end

    // Accumulate; a closing beat hands the frame to the queue
    assign n_sum = r_sum + SUM_W'(r_a_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_a_valid) begin
            r_sum <= r_a_close ? '0 : n_sum;
        end
    end

    assign o_push        = r_a_valid && r_a_close;
    assign o_frame.sum   = n_sum;
    assign o_frame.count = r_a_count;

endmodule

// File: rtl/rvad_back.sv
// Back end: mean square by restoring divide, integer root, hangover decision.
`timescale 1ns / 1ps
module rvad_back
    import rvad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame            i_frame,
    input  t_fifo_stat        i_stat,
    output logic              o_pop,
    input  logic [THR_W-1:0]  i_threshold,
    input  logic [HANG_W-1:0] i_hangover,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [E_W-1:0]    o_frame_energy,
    output logic              o_speaking
);

    t_back_state         r_state;
    t_back_state         n_state;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_div;
    logic [REM_W-1:0]    r_rem;
    logic [Q_W-1:0]      r_quo;
    logic [SQ_W-1:0]     r_root;
    logic [SQ_W-1:0]     r_bit;
    logic [SIL_W-1:0]    r_silence;
    logic                r_speaking;
    logic                r_out_valid;
    logic [E_W-1:0]      r_out_energy;

    logic                div_step;
    logic                root_step;
    logic                finish;
    logic                div_last;
    logic                root_last;
    logic [REM_W-1:0]    shifted;
    logic                div_ge;
    logic [SQ_W:0]       trial;
    logic                root_ge;
    logic [E_W-1:0]      energy;
    logic                speech;
    logic [SIL_W:0]      sil_sum;
    logic [SIL_W-1:0]    sil_sat;
    logic                n_speaking;

    assign div_last  = (r_step == STEP_W'(Q_W - 1));
    assign root_last = (r_step == STEP_W'(ROOT_STEPS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_stat.empty) n_state = BK_DIV;
            BK_DIV:  if (div_last)      n_state = BK_SQRT;
            BK_SQRT: if (root_last)     n_state = BK_DONE;
            BK_DONE: if (!r_out_valid || i_ready) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        o_pop     = 1'b0;
        div_step  = 1'b0;
        root_step = 1'b0;
        finish    = 1'b0;
        case (r_state)
            BK_IDLE: o_pop     = !i_stat.empty;
            BK_DIV:  div_step  = 1'b1;
            BK_SQRT: root_step = 1'b1;
            BK_DONE: finish    = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_IDLE;
        else          r_state <= n_state;
    end

    // One quotient bit per cycle; remainder stays below the frame length
    assign shifted = {r_rem[REM_W-2:0], r_quo[Q_W-1]};
    assign div_ge  = (shifted >= REM_W'(r_div));

    // One root bit per cycle, radicand kept in the quotient register
    assign trial   = (SQ_W+1)'(r_root) + (SQ_W+1)'(r_bit);
    assign root_ge = ((SQ_W+1)'(r_quo) >= trial);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_div  <= i_frame.count;
            r_rem  <= REM_W'(i_frame.sum >> Q_W);
            r_quo  <= i_frame.sum[Q_W-1:0];
            r_step <= '0;
        end else if (div_step) begin
            r_rem  <= div_ge ? (shifted - REM_W'(r_div)) : shifted;
            r_quo  <= {r_quo[Q_W-2:0], div_ge};
            r_step <= div_last ? '0 : r_step + STEP_W'(1);
            if (div_last) begin
                r_root <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 1);
            end
        end else if (root_step) begin
            if (root_ge) begin
                r_quo  <= r_quo - trial[SQ_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Clamp, threshold and saturating silence count
    assign energy  = (r_root > ENERGY_CLAMP) ? E_W'(ENERGY_CLAMP) : r_root[E_W-1:0];
    assign speech  = (energy > i_threshold);
    assign sil_sum = (SIL_W+1)'(r_silence) + (SIL_W+1)'(r_div);
    assign sil_sat = sil_sum[SIL_W] ? {SIL_W{1'b1}} : sil_sum[SIL_W-1:0];

    always_comb begin
        n_speaking = r_speaking;
        if (speech)                                 n_speaking = 1'b1;
        else if (sil_sat > SIL_W'(i_hangover))      n_speaking = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence   <= '0;
            r_speaking  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_silence   <= speech ? '0 : sil_sat;
            r_speaking  <= n_speaking;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) r_out_energy <= energy;
    end

    assign o_valid        = r_out_valid;
    assign o_frame_energy = r_out_energy;
    assign o_speaking     = r_speaking;

endmodule

// File: rtl/rms_voice_activity_detector_top.sv
// Top level of the RMS voice activity detector: APB registers, front, queue, back.
//
//  channel   direction  handshake           payload
//  sample    in         i_valid / o_ready   i_sample, i_frame_end
//  result    out        o_valid / i_ready   o_frame_energy, o_speaking
//  config    in         APB psel/penable    paddr, pwdata, prdata
//
// The front takes one sample beat per cycle while o_ready is high; the square is
// registered and reaches the accumulator on the next cycle. The back end pops a
// frame, divides (restoring), takes the root, one bit a cycle, and holds the result.
// Frames shorter than a back end pass fill the four-frame queue, then the front stalls.
// Reset is synchronous, active low; there is no clearing pass.
// A result waiting on i_ready holds the back end in its final state only.
`timescale 1ns / 1ps
module rms_voice_activity_detector_top
    import rvad_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [SMP_W-1:0]   i_sample,
    input  logic               i_frame_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [E_W-1:0]     o_frame_energy,
    output logic               o_speaking,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [THR_W-1:0]  r_threshold;
    logic [HANG_W-1:0] r_hangover;
    logic              wr_en;
    logic              push;
    logic              pop;
    t_frame            push_frame;
    t_frame            head_frame;
    t_fifo_stat        stat;

    // Register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
            r_hangover  <= HANG_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_THRESHOLD: r_threshold <= pwdata[THR_W-1:0];
                REG_HANGOVER:  r_hangover  <= pwdata[HANG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_THRESHOLD: prdata = PDATA_W'(r_threshold);
            REG_HANGOVER:  prdata = PDATA_W'(r_hangover);
            default:       prdata = '0;
        endcase
    end

    rvad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_frame_end (i_frame_end),
        .i_stat      (stat),
        .o_push      (push),
        .o_frame     (push_frame)
    );

    rvad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_frame (head_frame),
        .o_stat  (stat)
    );

    rvad_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame        (head_frame),
        .i_stat         (stat),
        .o_pop          (pop),
        .i_threshold    (r_threshold),
        .i_hangover     (r_hangover),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_energy (o_frame_energy),
        .o_speaking     (o_speaking)
    );

endmodule

// File: rtl/rvad_checker.sv
// Port-level checks for the RMS voice activity detector, bound to the top level.
`timescale 1ns / 1ps
module rvad_checker
    import rvad_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [E_W-1:0]     o_frame_energy,
    input logic               o_speaking,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata
);

    // A stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_energy) && $stable(o_speaking))
        else $error("result beat changed while stalled");

    // Energy never exceeds full scale
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_frame_energy <= E_W'(32768))
        else $error("frame energy above clamp");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Threshold readback follows the last write
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) && $past(i_rst_n)
        && (paddr[2] == REG_THRESHOLD)
        |-> prdata == PDATA_W'($past(pwdata[THR_W-1:0])))
        else $error("threshold readback mismatch");

endmodule

bind rms_voice_activity_detector_top rvad_checker u_rvad_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_frame_energy (o_frame_energy),
    .o_speaking     (o_speaking),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
);

// File: tb/rms_voice_activity_detector_top_test.sv
// Self-checking testbench for the RMS voice activity detector top level.
`timescale 1ns / 1ps
module rms_voice_activity_detector_top_test
    import rvad_pkg::*;
;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 64;     // one back end pass plus accumulator slack
    localparam int HOLD_CYCLES   = 500;
    localparam int unsigned ENERGY_MAX  = 32768;
    localparam int unsigned SILENCE_SAT = (1 << SIL_W) - 1;

    // Expected content of one result beat
    typedef struct packed {
        logic [E_W-1:0] energy;
        logic           speaking;
    } t_frame_verdict;

    // Amplitude families for random frames
    typedef enum int {
        AMP_QUIET,
        AMP_AT_THRESHOLD,
        AMP_RANDOM,
        AMP_FULL,
        AMP_RAW_BITS
    } t_amp_kind;

    // Frame energy / hangover predictor and result checker
    class vad_frame_checker;
        logic [THR_W-1:0]  thr;
        logic [HANG_W-1:0] hang;
        logic [63:0]       sq_sum;
        int unsigned       n_in_frame;
        logic [SIL_W-1:0]  silent_run;
        logic              talking;
        t_frame_verdict    frames_due[$];
        int unsigned       fails;

        function new();
            thr        = THR_RESET;
            hang       = HANG_RESET;
            sq_sum     = '0;
            n_in_frame = 0;
            silent_run = '0;
            talking    = 1'b0;
            fails      = 0;
        endfunction

        // Floor square root, one result bit per pass
        function logic [31:0] floor_root(logic [63:0] v);
            logic [31:0] r;
            logic [31:0] t;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (32'd1 << b);
                if (64'(t) * 64'(t) <= v) r = t;
            end
            return r;
        endfunction

        // Accumulate one accepted sample beat; queue a verdict when the frame closes
        function void note_sample(logic [SMP_W-1:0] s, logic fe);
            logic [SMP_W:0] mag;
            logic [63:0]    mean;
            logic [63:0]    energy;
            logic [63:0]    run;
            t_frame_verdict v;
            mag = s[SMP_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
            sq_sum += 64'(mag) * 64'(mag);
            n_in_frame++;
            if (!fe && n_in_frame < FRAME_MAX) return;
            mean   = sq_sum / 64'(n_in_frame);
            energy = 64'(floor_root(mean));
            if (energy > 64'(ENERGY_MAX)) energy = 64'(ENERGY_MAX);
            if (energy > 64'(thr)) begin
                silent_run = '0;
                talking    = 1'b1;
            end else begin
                run = 64'(silent_run) + 64'(n_in_frame);
                if (run > 64'(SILENCE_SAT)) run = 64'(SILENCE_SAT);
                silent_run = run[SIL_W-1:0];
                if (silent_run > 25'(hang)) talking = 1'b0;
            end
            v.energy   = energy[E_W-1:0];
            v.speaking = talking;
            frames_due.push_back(v);
            sq_sum     = '0;
            n_in_frame = 0;
        endfunction

        // Compare one result beat with the oldest queued verdict
        function void check_result(logic [E_W-1:0] energy, logic speaking);
            t_frame_verdict want;
            if (frames_due.size() == 0) begin
                $error("unexpected result: frame_energy %0d speaking %0b", energy, speaking);
                fails++;
                return;
            end
            want = frames_due.pop_front();
            if (energy !== want.energy) begin
                $error("frame_energy: expected %0d, actual %0d", want.energy, energy);
                fails++;
            end
            if (speaking !== want.speaking) begin
                $error("speaking: expected %0b, actual %0b", want.speaking, speaking);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    logic [SMP_W-1:0]   i_sample    = '0;
    logic               i_frame_end = 1'b0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    logic [E_W-1:0]     o_frame_energy;
    logic               o_speaking;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    vad_frame_checker sb = new();
    int unsigned      n_sent  = 0;
    bit               tx_idle = 1'b1;
    bit               rx_idle = 1'b1;
    bit               hold_req = 1'b0;

    rms_voice_activity_detector_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_energy (o_frame_energy),
        .o_speaking     (o_speaking),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Beat monitor: result beats checked, sample beats fed to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_frame_energy, o_speaking);
            if (i_valid && o_ready) sb.note_sample(i_sample, i_frame_end);
        end
    end

    // Result side ready: random stall bursts, plus a long hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned gap_left;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                i_ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 8);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one sample beat and wait until it is taken
    task automatic send_sample(input logic [SMP_W-1:0] s, input logic fe);
        int unsigned gap;
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample    <= s;
        i_frame_end <= fe;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Sample with magnitude in [lo, hi]; random sign, but 32768 is always negative
    function automatic logic [SMP_W-1:0] rand_sample(input int unsigned lo,
                                                     input int unsigned hi);
        int unsigned mag;
        mag = $urandom_range(lo, hi);
        if (mag == ENERGY_MAX || (mag != 0 && $urandom_range(0, 1) == 1))
            return SMP_W'(-int'(mag));
        return SMP_W'(mag);
    endfunction

    // One frame of random length and amplitude family
    task automatic send_random_frame(input int unsigned len_max);
        int unsigned len;
        int unsigned lo;
        int unsigned hi;
        t_amp_kind   kind;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8 * len_max)
                                           : $urandom_range(1, len_max);
        kind = t_amp_kind'($urandom_range(0, 4));
        lo   = 0;
        hi   = ENERGY_MAX;
        case (kind)
            AMP_QUIET: begin
                hi = sb.thr / 2;
            end
            AMP_AT_THRESHOLD: begin
                // constant magnitude lands exactly on or one above the threshold
                lo = sb.thr + $urandom_range(0, 1);
                if (lo > ENERGY_MAX) lo = ENERGY_MAX;
                hi = lo;
            end
            AMP_RANDOM: begin
                hi = $urandom_range(0, ENERGY_MAX);
            end
            default: begin
            end
        endcase
        for (int unsigned k = 0; k < len; k++) begin
            if (kind == AMP_RAW_BITS) send_sample(SMP_W'($urandom()), k == len - 1);
            else send_sample(rand_sample(lo, hi), k == len - 1);
        end
    endtask

    // Drop valid, wait out all pending results and the back end
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.frames_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup then access cycle
    task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_THRESHOLD) sb.thr = val[THR_W-1:0];
        else sb.hang = val[HANG_W-1:0];
    endtask

    // APB read with readback check
    task automatic reg_read(input logic idx, input logic [PDATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, want, prdata);
            sb.fails++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // New register setting, then a batch of random frames
    task automatic run_phase(input int unsigned thr, input int unsigned hang,
                             input int unsigned n_items, input bit pressure);
        logic [31:0] junk;
        int unsigned goal;
        settle();
        junk = $urandom();
        // upper pwdata bits are junk; the registers keep only their own width
        reg_write(REG_THRESHOLD, {junk[31:16], THR_W'(thr)});
        reg_write(REG_HANGOVER, {junk[7:0], HANG_W'(hang)});
        reg_read(REG_THRESHOLD, PDATA_W'(sb.thr));
        reg_read(REG_HANGOVER, PDATA_W'(sb.hang));
        if (pressure) begin
            // short frames while results are held back fill the frame queue
            hold_req = 1'b1;
            repeat (30) send_random_frame(2);
        end
        goal = n_sent + n_items;
        while (n_sent < goal) send_random_frame(24);
    endtask

    // Main sequence
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        reg_read(REG_THRESHOLD, PDATA_W'(THR_RESET));
        reg_read(REG_HANGOVER, PDATA_W'(HANG_RESET));

        // directed frames at reset settings
        send_sample(16'h8000, 1'b1);                 // most negative: energy clamp edge
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(SMP_W'(655), 1'b0);              // energy equal to threshold: silent
        send_sample(SMP_W'(-655), 1'b1);
        send_sample(SMP_W'(656), 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);

        // register write in the middle of a frame keeps the partial sums
        send_sample(SMP_W'(1000), 1'b0);
        send_sample(SMP_W'(-1000), 1'b0);
        send_sample(SMP_W'(1000), 1'b0);
        settle();
        reg_write(REG_THRESHOLD, PDATA_W'(2000));
        send_sample(SMP_W'(-1000), 1'b1);
        settle();
        reg_write(REG_THRESHOLD, PDATA_W'(THR_RESET));

        // one loud single-sample frame at the default threshold
        send_sample(SMP_W'(700), 1'b1);

        // zero threshold and zero hangover
        settle();
        reg_write(REG_THRESHOLD, '0);
        reg_write(REG_HANGOVER, '0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b1);
        send_sample(16'h0000, 1'b1);

        // random phases
        run_phase($urandom_range(200, 3000), $urandom_range(0, 400), 150, 1'b0);
        run_phase(ENERGY_MAX, (1 << HANG_W) - 1, 150, 1'b0);
        run_phase(0, 0, 100, 1'b0);
        run_phase($urandom_range(100, 2000), $urandom_range(0, 200), 150, 1'b1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_phase($urandom_range(0, ENERGY_MAX), $urandom_range(0, 300), 150, 1'b0);

        settle();
        if (sb.fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rvad_pkg.sv
rtl/rvad_fifo.sv
rtl/rvad_front.sv
rtl/rvad_back.sv
rtl/rms_voice_activity_detector_top.sv
rtl/rvad_checker.sv
tb/rms_voice_activity_detector_top_test.sv
